// ===== hdl/gamepad_report_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Gamepad report decoder assertion macros
// Shared property shapes for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_REPORT_DECODER_DEFINES_SVH
`define GAMEPAD_REPORT_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define GPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gamepad_report_decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define GPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gamepad_report_decoder: next-cycle check failed");

`endif

// ===== hdl/gpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamepad report decoder package
// Payload types, sequencer step numbers and the hat lookup.
// ----------------------------------------------------------------------------
package gpd_pkg;

    // Number of pads with smoothing state.
    localparam int NUM_PADS  = 8;
    localparam int PAD_IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    // Sequencer step numbers shared by all lanes.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_SQUARE    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SUM       = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PRODUCT   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DIV_LAST  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_ACC_LOAD  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ACC_SCALE = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LAST      = 4'd9;

    // Stick correction quotient never exceeds 16; accel quotient stays below 512.
    localparam int STICK_Q_W = 6;
    localparam int ACC_Q_W   = 9;
    localparam int ACC_DIV   = 8315;
    localparam int ACC_MUL   = 113;

    // Division by 8315 as a multiply by ceil(2^36 / 8315) and a shift; exact
    // for every numerator below 2^22.
    localparam int ACC_RECIP = 8264520;
    localparam int ACC_SHIFT = 36;

    typedef struct packed {
        logic        [2:0]  pad_index;
        logic        [7:0]  left_x_raw;
        logic        [7:0]  left_y_raw;
        logic        [7:0]  right_x_raw;
        logic        [7:0]  right_y_raw;
        logic        [15:0] button_bytes;
        logic        [7:0]  left_trigger_raw;
        logic        [7:0]  right_trigger_raw;
        logic signed [15:0] accel_x_raw;
        logic signed [15:0] accel_y_raw;
        logic signed [15:0] accel_z_raw;
        logic signed [15:0] gyro_yaw_raw;
    } t_gpd_in;

    typedef struct packed {
        logic [7:0]  left_x_out;
        logic [7:0]  left_y_out;
        logic [7:0]  right_x_out;
        logic [7:0]  right_y_out;
        logic [13:0] digital_mask;
        logic [7:0]  left_trigger_out;
        logic [7:0]  right_trigger_out;
        logic [9:0]  accel_x_out;
        logic [9:0]  accel_y_out;
        logic [9:0]  accel_z_out;
        logic [9:0]  gyro_out;
        logic        hat_error;
    } t_gpd_out;

    // Sequencer control seen by every lane.
    typedef struct packed {
        logic              run;
        logic [STEP_W-1:0] step;
        logic              commit;
        logic [2:0]        pad;
    } t_gpd_ctl;

    // Hat nibble to {right, left, down, up}; codes from eight up have no direction.
    function automatic logic [3:0] hat_dirs(input logic [3:0] hat);
        logic [3:0] dirs;
        case (hat)
            4'd0:    dirs = 4'b0001;
            4'd1:    dirs = 4'b1001;
            4'd2:    dirs = 4'b1000;
            4'd3:    dirs = 4'b1010;
            4'd4:    dirs = 4'b0010;
            4'd5:    dirs = 4'b0110;
            4'd6:    dirs = 4'b0100;
            4'd7:    dirs = 4'b0101;
            default: dirs = 4'b0000;
        endcase
        return dirs;
    endfunction

endpackage

// ===== hdl/gpd_if.sv =====
// ----------------------------------------------------------------------------
// Gamepad report decoder channels
// Valid/ready interfaces for the report and the decoded result.
// ----------------------------------------------------------------------------
interface gpd_in_if;
    import gpd_pkg::*;
    logic    valid;
    logic    ready;
    t_gpd_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gpd_out_if;
    import gpd_pkg::*;
    logic     valid;
    logic     ready;
    t_gpd_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/gpd_stick_lane.sv =====
// ----------------------------------------------------------------------------
// Gamepad stick lane
// Squircle remap of one stick axis with a serial divider, then smoothing.
// ----------------------------------------------------------------------------
module gpd_stick_lane
    import gpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_gpd_ctl i_ctl,
    input  logic [7:0] i_own_raw,
    input  logic [7:0] i_other_raw,
    output logic [7:0] o_value
);

    logic signed [8:0]  w_d_own;
    logic signed [8:0]  w_d_oth;
    logic [7:0]         w_abs_own;
    logic [7:0]         w_abs_oth;
    logic [15:0]        w_sq_own;
    logic [15:0]        w_sq_oth;
    logic [29:0]        w_p;
    logic [31:0]        w_s2;
    logic [37:0]        w_num;
    logic [2:0]         w_bit;
    logic [37:0]        w_trial;
    logic [STICK_Q_W-1:0] w_qm;
    logic signed [10:0] w_val;
    logic [7:0]         w_sq_val;
    logic [7:0]         w_old;
    logic [8:0]         w_sum;
    logic               w_pad_ok;
    logic [PAD_IDX_W-1:0] w_idx;

    logic [14:0]          r_sq_own;
    logic [14:0]          r_sq_oth;
    logic [15:0]          r_s;
    logic [29:0]          r_p;
    logic [31:0]          r_den;
    logic [37:0]          r_rem;
    logic [STICK_Q_W-1:0] r_q;
    logic [7:0]           r_avg [NUM_PADS];

    // Offsets from the stick centre and their magnitudes.
    assign w_d_own   = $signed({1'b0, i_own_raw}) - 9'sd127;
    assign w_d_oth   = $signed({1'b0, i_other_raw}) - 9'sd127;
    assign w_abs_own = w_d_own[8] ? 8'(-w_d_own) : w_d_own[7:0];
    assign w_abs_oth = w_d_oth[8] ? 8'(-w_d_oth) : w_d_oth[7:0];
    assign w_sq_own  = w_abs_own * w_abs_own;
    assign w_sq_oth  = w_abs_oth * w_abs_oth;
    assign w_p       = r_sq_own * r_sq_oth;
    assign w_s2      = r_s * r_s;
    assign w_num     = w_abs_own * r_p;

    // One quotient bit per divide step, most significant first.
    assign w_bit   = 3'(STEP_DIV_LAST - i_ctl.step);
    assign w_trial = {6'd0, r_den} << w_bit;

    // Multiply stages, then restoring division of |d|*dx2*dy2 by 2*S^2.
    always_ff @(posedge i_clk) begin
        if (i_ctl.run) begin
            case (i_ctl.step)
                STEP_SQUARE: begin
                    r_sq_own <= w_sq_own[14:0];
                    r_sq_oth <= w_sq_oth[14:0];
                end
                STEP_SUM: begin
                    r_s <= {1'b0, r_sq_own} + {1'b0, r_sq_oth};
                    r_p <= w_p;
                end
                STEP_PRODUCT: begin
                    r_den <= {w_s2[30:0], 1'b0};
                    r_rem <= w_num;
                    r_q   <= '0;
                end
                default: begin
                    if (i_ctl.step <= STEP_DIV_LAST && r_rem >= w_trial) begin
                        r_rem        <= r_rem - w_trial;
                        r_q[w_bit]   <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Floor the correction, add it to the offset and clamp to a byte.
    always_comb begin
        w_qm  = r_q + STICK_Q_W'(w_d_own[8] && (r_rem != '0));
        w_val = 11'sd127 + $signed({{2{w_d_own[8]}}, w_d_own})
              + (w_d_own[8] ? -$signed({5'd0, w_qm}) : $signed({5'd0, w_qm}));
        if (r_s == '0) begin
            w_sq_val = 8'd127;
        end else if (w_val < 0) begin
            w_sq_val = 8'd0;
        end else if (w_val > 11'sd255) begin
            w_sq_val = 8'd255;
        end else begin
            w_sq_val = w_val[7:0];
        end
    end

    // Average with the value kept for this pad.
    assign w_pad_ok = {1'b0, i_ctl.pad} < 5'(NUM_PADS);
    assign w_idx    = PAD_IDX_W'(i_ctl.pad);
    assign w_old    = w_pad_ok ? r_avg[w_idx] : 8'd0;
    assign w_sum    = {1'b0, w_sq_val} + {1'b0, w_old};
    assign o_value  = w_sum[8:1];

    // Smoothing state is written when the result is handed on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PADS; i++) begin
                r_avg[i] <= 8'd0;
            end
        end else if (i_ctl.commit && w_pad_ok) begin
            r_avg[w_idx] <= w_sum[8:1];
        end
    end

endmodule

// ===== hdl/gpd_accel_div.sv =====
// ----------------------------------------------------------------------------
// Gamepad accelerometer scaler
// Computes floor(512 - v*113/8315) with a reciprocal multiply, clamped to 10 bits.
// ----------------------------------------------------------------------------
module gpd_accel_div
    import gpd_pkg::*;
(
    input  logic              i_clk,
    input  t_gpd_ctl          i_ctl,
    input  logic signed [15:0] i_raw,
    output logic [9:0]        o_value
);

    logic [15:0]        w_abs;
    logic [21:0]        w_num;
    logic [44:0]        w_prod;
    logic signed [11:0] w_val;
    logic               w_neg;

    logic [21:0]        r_num;
    logic [ACC_Q_W-1:0] r_q;

    // The numerator -v*113 is negative when the sample is positive.
    assign w_neg  = !i_raw[15] && (i_raw != 16'sd0);
    assign w_abs  = i_raw[15] ? 16'(-i_raw) : i_raw;
    assign w_num  = w_abs * 22'(ACC_MUL);
    assign w_prod = r_num * 45'(ACC_RECIP);

    // Product on the first step; a negative numerator is biased so that the
    // quotient rounds up. The reciprocal multiply follows on the next step.
    always_ff @(posedge i_clk) begin
        if (i_ctl.run) begin
            if (i_ctl.step == STEP_ACC_LOAD) begin
                r_num <= w_neg ? w_num + 22'(ACC_DIV - 1) : w_num;
            end else if (i_ctl.step == STEP_ACC_SCALE) begin
                r_q <= w_prod[ACC_SHIFT +: ACC_Q_W];
            end
        end
    end

    // Recentre and clamp.
    always_comb begin
        w_val = w_neg ? 12'sd512 - $signed({3'd0, r_q}) : 12'sd512 + $signed({3'd0, r_q});
        if (w_val < 0) begin
            o_value = 10'd0;
        end else if (w_val > 12'sd1023) begin
            o_value = 10'd1023;
        end else begin
            o_value = w_val[9:0];
        end
    end

endmodule

// ===== hdl/gpd_merge.sv =====
// ----------------------------------------------------------------------------
// Gamepad result merge
// Gathers the lane results, decodes buttons and hat, and scales the gyro.
// ----------------------------------------------------------------------------
module gpd_merge
    import gpd_pkg::*;
(
    input  t_gpd_in    i_in,
    input  logic [7:0] i_stick [4],
    input  logic [9:0] i_accel [3],
    output t_gpd_out   o_out
);

    logic [3:0]         w_hat;
    logic               w_hat_bad;
    logic signed [15:0] w_gyro_t;
    logic signed [11:0] w_gyro_val;

    assign w_hat     = i_in.button_bytes[3:0];
    assign w_hat_bad = w_hat > 4'd8;

    // Gyro divided by 128 with truncation toward zero.
    assign w_gyro_t = (i_in.gyro_yaw_raw >>> 7)
                    + 16'sd1 * $signed({15'd0, i_in.gyro_yaw_raw[15]
                                        && (i_in.gyro_yaw_raw[6:0] != 7'd0)});
    assign w_gyro_val = 12'sd512 - 12'(w_gyro_t);

    // Assemble one result.
    always_comb begin
        o_out.left_x_out        = i_stick[0];
        o_out.left_y_out        = i_stick[1];
        o_out.right_x_out       = i_stick[2];
        o_out.right_y_out       = i_stick[3];
        o_out.digital_mask      = {i_in.button_bytes[15:12], i_in.button_bytes[9:8],
                                   i_in.button_bytes[7:4], hat_dirs(w_hat)};
        o_out.left_trigger_out  = i_in.left_trigger_raw;
        o_out.right_trigger_out = i_in.right_trigger_raw;
        o_out.accel_x_out       = i_accel[0];
        o_out.accel_y_out       = i_accel[1];
        o_out.accel_z_out       = i_accel[2];
        if (w_gyro_val < 0) begin
            o_out.gyro_out = 10'd0;
        end else if (w_gyro_val > 12'sd1023) begin
            o_out.gyro_out = 10'd1023;
        end else begin
            o_out.gyro_out = w_gyro_val[9:0];
        end
        o_out.hat_error = w_hat_bad;
    end

endmodule

// ===== hdl/gamepad_report_decoder.sv =====
// ----------------------------------------------------------------------------
// Gamepad report decoder
// Channel      | Dir | Contents
// i_in         | in  | one report for one pad
// o_out        | out | remapped sticks, buttons, triggers, motion
//
// After the report transfer the sequencer runs ten steps shared by four
// stick lanes (three multiply steps and a six-step divider) and three
// accelerometer lanes (a product step and a reciprocal multiply step); the
// result is then registered in the done state and offered. The next report
// is taken only once the sequencer is back in idle, and a result that is
// still waiting holds the sequencer in its done state. Reset clears the
// per-pad smoothing state at once.
// ----------------------------------------------------------------------------
module gamepad_report_decoder
    import gpd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gpd_in_if.sink    i_in,
    gpd_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step;
    t_gpd_in           r_in;
    t_gpd_out          r_out;
    logic              r_out_valid;

    t_gpd_ctl   w_ctl;
    logic       w_load;
    logic [7:0] w_stick [4];
    logic [9:0] w_accel [3];
    t_gpd_out   w_result;

    assign w_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign w_ctl.run    = (r_state == S_RUN);
    assign w_ctl.step   = r_step;
    assign w_ctl.commit = w_load;
    assign w_ctl.pad    = r_in.pad_index;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_step == STEP_LAST) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer registers and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    // Report capture on input transfer.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    // Stick lanes: each axis pairs with the other axis of its stick.
    gpd_stick_lane u_lane_lx (.i_clk, .i_rst_n, .i_ctl(w_ctl),
        .i_own_raw(r_in.left_x_raw),  .i_other_raw(r_in.left_y_raw),  .o_value(w_stick[0]));
    gpd_stick_lane u_lane_ly (.i_clk, .i_rst_n, .i_ctl(w_ctl),
        .i_own_raw(r_in.left_y_raw),  .i_other_raw(r_in.left_x_raw),  .o_value(w_stick[1]));
    gpd_stick_lane u_lane_rx (.i_clk, .i_rst_n, .i_ctl(w_ctl),
        .i_own_raw(r_in.right_x_raw), .i_other_raw(r_in.right_y_raw), .o_value(w_stick[2]));
    gpd_stick_lane u_lane_ry (.i_clk, .i_rst_n, .i_ctl(w_ctl),
        .i_own_raw(r_in.right_y_raw), .i_other_raw(r_in.right_x_raw), .o_value(w_stick[3]));

    // Accelerometer lanes.
    gpd_accel_div u_acc_x (.i_clk, .i_ctl(w_ctl), .i_raw(r_in.accel_x_raw), .o_value(w_accel[0]));
    gpd_accel_div u_acc_y (.i_clk, .i_ctl(w_ctl), .i_raw(r_in.accel_y_raw), .o_value(w_accel[1]));
    gpd_accel_div u_acc_z (.i_clk, .i_ctl(w_ctl), .i_raw(r_in.accel_z_raw), .o_value(w_accel[2]));

    gpd_merge u_merge (.i_in(r_in), .i_stick(w_stick), .i_accel(w_accel), .o_out(w_result));

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// ===== hdl/gpd_checker.sv =====
// ----------------------------------------------------------------------------
// Gamepad report decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "gamepad_report_decoder_defines.svh"

module gpd_checker
    import gpd_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     i_in_ready,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_gpd_out i_out_data
);

    // A held result stays offered.
    `GPD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // A held result keeps its payload.
    `GPD_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_data))

    // After a report transfer the decoder is busy.
    `GPD_ASSERT_NEXT(a_busy_after_in, i_in_valid && i_in_ready, !i_in_ready)

    // A bad hat code clears every direction.
    `GPD_ASSERT_NOW(a_hat_error_dirs, i_out_valid && i_out_data.hat_error,
        i_out_data.digital_mask[3:0] == 4'd0)

    // Opposite directions never show together.
    `GPD_ASSERT_NOW(a_hat_opposite, i_out_valid,
        !(i_out_data.digital_mask[0] && i_out_data.digital_mask[1])
        && !(i_out_data.digital_mask[2] && i_out_data.digital_mask[3]))

endmodule

bind gamepad_report_decoder gpd_checker u_gpd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
